@@ rtl/core/srprs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Survival pairwise rank score package
// Shared widths, defaults and payload types of the rank score block.
// ----------------------------------------------------------------------------
package srprs_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int ID_W      = 16;
  localparam int TIME_W    = 24;
  localparam int RAW_W     = 24;
  localparam int NORM_FRAC = 16;
  localparam int NORM_W    = NORM_FRAC + 1;
  localparam int DIV_W     = RAW_W + NORM_FRAC;
  localparam int DCNT_W    = $clog2(DIV_W);

  typedef logic [ID_W-1:0]   rec_id_t;
  typedef logic [TIME_W-1:0] surv_time_t;
  typedef logic [RAW_W-1:0]  raw_score_t;
  typedef logic [NORM_W-1:0] norm_score_t;

endpackage

@@ rtl/core/srprs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Survival pairwise rank score channels
// Valid/ready channels for input records and normalized score results.
// ----------------------------------------------------------------------------
interface srprs_in_if
  import srprs_pkg::*;
();
  logic       valid;
  logic       ready;
  rec_id_t    record_id;
  surv_time_t surv_time;
  logic       event_seen;
  logic       last_record;

  modport source (output valid, record_id, surv_time, event_seen, last_record,
                  input ready);
  modport sink (input valid, record_id, surv_time, event_seen, last_record,
                output ready);
endinterface

interface srprs_out_if
  import srprs_pkg::*;
();
  logic        valid;
  logic        ready;
  rec_id_t     out_id;
  norm_score_t norm_score;
  logic        flat_range;
  logic        out_last;

  modport source (output valid, out_id, norm_score, flat_range, out_last,
                  input ready);
  modport sink (input valid, out_id, norm_score, flat_range, out_last,
                output ready);
endinterface

@@ rtl/core/survival_pairwise_rank_score_top.sv @@
// Loading accepts one record beat per cycle; the run starts after the beat marked last.
// Pair shares that need a ratio and non-flat normalized scores use a shared 40-step restoring divider.
// The block takes no record during a run; results leave one at a time.
// Reset is synchronous and active low; it empties the store and returns to loading.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Survival pairwise rank score
// Ranks records by id, counts those at risk, scores every pair through a
// shared serial divider, then emits min-max normalized scores by record id.
// ----------------------------------------------------------------------------
module survival_pairwise_rank_score_top
  import srprs_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  srprs_in_if.sink     in_rec,
  srprs_out_if.source  out_res
);

  localparam int IW   = $clog2(MAX_RECORDS);
  localparam int CW   = $clog2(MAX_RECORDS + 1);
  localparam int SHW  = FRAC_BITS + 1;
  localparam int SUMW = ((SHW > RAW_W) ? SHW : RAW_W) + 1;
  localparam logic [SHW-1:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SHW-1:0]   HALF    = ONE >> 1;
  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
  localparam logic [CW-1:0]    MAX_CNT = CW'(MAX_RECORDS);

  localparam logic [4:0] ST_LOAD    = 5'd0;
  localparam logic [4:0] ST_RK_I    = 5'd1;
  localparam logic [4:0] ST_RK_I2   = 5'd2;
  localparam logic [4:0] ST_RK_JA   = 5'd3;
  localparam logic [4:0] ST_RK_JB   = 5'd4;
  localparam logic [4:0] ST_RK_W    = 5'd5;
  localparam logic [4:0] ST_PR_I    = 5'd6;
  localparam logic [4:0] ST_PR_I2   = 5'd7;
  localparam logic [4:0] ST_PR_JA   = 5'd8;
  localparam logic [4:0] ST_PR_JB   = 5'd9;
  localparam logic [4:0] ST_PR_DIV  = 5'd10;
  localparam logic [4:0] ST_PR_FIN  = 5'd11;
  localparam logic [4:0] ST_PR_UPD  = 5'd12;
  localparam logic [4:0] ST_PR_WI   = 5'd13;
  localparam logic [4:0] ST_MM_A    = 5'd14;
  localparam logic [4:0] ST_MM_B    = 5'd15;
  localparam logic [4:0] ST_OUT_A   = 5'd16;
  localparam logic [4:0] ST_OUT_B   = 5'd17;
  localparam logic [4:0] ST_OUT_C   = 5'd18;
  localparam logic [4:0] ST_OUT_DIV = 5'd19;
  localparam logic [4:0] ST_OUT_FIN = 5'd20;
  localparam logic [4:0] ST_OUT_V   = 5'd21;

  function automatic raw_score_t sat_add(raw_score_t a, logic [SHW-1:0] b);
    logic [SUMW-1:0] s;
    s = SUMW'(a) + SUMW'(b);
    return (s > SUMW'(RAW_MAX)) ? RAW_MAX : s[RAW_W-1:0];
  endfunction

  surv_time_t time_mem [MAX_RECORDS];
  logic       ev_mem   [MAX_RECORDS];
  rec_id_t    id_mem   [MAX_RECORDS];
  logic [CW-1:0] risk_mem [MAX_RECORDS];
  raw_score_t raw_mem  [MAX_RECORDS];
  logic [IW-1:0] ord_mem [MAX_RECORDS];

  surv_time_t    time_q;
  logic          ev_q;
  rec_id_t       id_q;
  logic [CW-1:0] risk_q;
  raw_score_t    raw_q;
  logic [IW-1:0] ord_q;

  logic          ld_we;
  logic [IW-1:0] m_ra;
  logic          rk_we;
  logic          raw_we;
  logic [IW-1:0] raw_wa;
  raw_score_t    raw_wd;
  logic [IW-1:0] raw_ra;
  logic [IW-1:0] ord_ra;

  logic [4:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [IW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     evc_r, evc_nxt;
  logic [IW-1:0]     idr_r, idr_nxt;
  surv_time_t        ti_r, ti_nxt;
  logic              ei_r, ei_nxt;
  rec_id_t           idi_r, idi_nxt;
  logic [CW-1:0]     ri_r, ri_nxt;
  raw_score_t        acc_r, acc_nxt;
  raw_score_t        rawj_r, rawj_nxt;
  logic [SHW-1:0]    sa_r, sa_nxt;
  logic [SHW-1:0]    sb_r, sb_nxt;
  logic              aisi_r, aisi_nxt;
  raw_score_t        lo_r, lo_nxt;
  raw_score_t        hi_r, hi_nxt;
  rec_id_t           oid_r, oid_nxt;
  norm_score_t       norm_r, norm_nxt;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [RAW_W-1:0]  dsr_r, dsr_nxt;
  logic [RAW_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic [CW-1:0]  nm1;
  logic           j_last;
  logic           i_last;
  logic           flat;
  logic           in_acc;
  logic [RAW_W:0] rem_sh;
  logic           ge;
  logic [RAW_W:0] rem_sub;
  logic           t_earlier;
  logic           id_before;
  logic           pj_aisi;
  logic           pj_ea;
  logic           pj_eb;
  logic [CW-1:0]  pj_ra;
  logic [CW-1:0]  pj_rb;
  logic [SHW-1:0] si;
  logic [SHW-1:0] sj;

  assign nm1     = cnt_r - CW'(1);
  assign j_last  = CW'(j_r) == nm1;
  assign i_last  = CW'(i_r) == nm1;
  assign flat    = hi_r == lo_r;
  assign in_acc  = in_rec.valid && in_rec.ready;

  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  assign t_earlier = (time_q < ti_r) || ((time_q == ti_r) && (j_r < i_r));
  assign id_before = (id_q < idi_r) || ((id_q == idi_r) && (j_r < i_r));
  assign pj_aisi   = ti_r <= time_q;
  assign pj_ea     = pj_aisi ? ei_r : ev_q;
  assign pj_eb     = pj_aisi ? ev_q : ei_r;
  assign pj_ra     = pj_aisi ? ri_r : risk_q;
  assign pj_rb     = pj_aisi ? risk_q : ri_r;
  assign si        = aisi_r ? sa_r : sb_r;
  assign sj        = aisi_r ? sb_r : sa_r;

  assign ld_we  = in_acc && (cnt_r != MAX_CNT);
  assign rk_we  = state_r == ST_RK_W;
  assign m_ra   = (state_r == ST_OUT_B) ? ord_q :
                  ((state_r == ST_RK_JA) || (state_r == ST_PR_JA)) ? j_r : i_r;
  assign raw_ra = m_ra;
  assign ord_ra = i_r;

  always_comb begin
    raw_we = 1'b0;
    raw_wa = i_r;
    raw_wd = '0;
    case (state_r)
      ST_RK_W: begin
        raw_we = 1'b1;
      end
      ST_PR_UPD: begin
        raw_we = 1'b1;
        raw_wa = j_r;
        raw_wd = sat_add(rawj_r, sj);
      end
      ST_PR_WI: begin
        raw_we = 1'b1;
        raw_wd = acc_r;
      end
      default: begin
        raw_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      time_mem[cnt_r[IW-1:0]] <= in_rec.surv_time;
      ev_mem[cnt_r[IW-1:0]]   <= in_rec.event_seen;
      id_mem[cnt_r[IW-1:0]]   <= in_rec.record_id;
    end
    time_q <= time_mem[m_ra];
    ev_q   <= ev_mem[m_ra];
    id_q   <= id_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      risk_mem[i_r] <= cnt_r - evc_r;
    end
    risk_q <= risk_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      ord_mem[idr_r] <= i_r;
    end
    ord_q <= ord_mem[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_mem[raw_wa] <= raw_wd;
    end
    raw_q <= raw_mem[raw_ra];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    evc_nxt   = evc_r;
    idr_nxt   = idr_r;
    ti_nxt    = ti_r;
    ei_nxt    = ei_r;
    idi_nxt   = idi_r;
    ri_nxt    = ri_r;
    acc_nxt   = acc_r;
    rawj_nxt  = rawj_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    aisi_nxt  = aisi_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    oid_nxt   = oid_r;
    norm_nxt  = norm_r;
    dvd_nxt   = dvd_r;
    dsr_nxt   = dsr_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dcnt_nxt  = dcnt_r;

    if ((state_r == ST_PR_DIV) || (state_r == ST_OUT_DIV)) begin
      dvd_nxt  = dvd_r << 1;
      rem_nxt  = ge ? rem_sub[RAW_W-1:0] : rem_sh[RAW_W-1:0];
      quo_nxt  = {quo_r[DIV_W-2:0], ge};
      dcnt_nxt = dcnt_r - DCNT_W'(1);
    end

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r != MAX_CNT) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_rec.last_record) begin
            i_nxt     = '0;
            state_nxt = ST_RK_I;
          end
        end
      end
      ST_RK_I: begin
        state_nxt = ST_RK_I2;
      end
      ST_RK_I2: begin
        ti_nxt    = time_q;
        ei_nxt    = ev_q;
        idi_nxt   = id_q;
        j_nxt     = '0;
        evc_nxt   = '0;
        idr_nxt   = '0;
        state_nxt = ST_RK_JA;
      end
      ST_RK_JA: begin
        state_nxt = ST_RK_JB;
      end
      ST_RK_JB: begin
        if ((t_earlier || (j_r == i_r)) && ev_q) begin
          evc_nxt = evc_r + CW'(1);
        end
        if (id_before) begin
          idr_nxt = idr_r + IW'(1);
        end
        j_nxt     = j_r + IW'(1);
        state_nxt = j_last ? ST_RK_W : ST_RK_JA;
      end
      ST_RK_W: begin
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = (cnt_r == CW'(1)) ? ST_MM_A : ST_PR_I;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = ST_RK_I;
        end
      end
      ST_PR_I: begin
        state_nxt = ST_PR_I2;
      end
      ST_PR_I2: begin
        ti_nxt    = time_q;
        ei_nxt    = ev_q;
        ri_nxt    = risk_q;
        acc_nxt   = raw_q;
        j_nxt     = i_r + IW'(1);
        state_nxt = ST_PR_JA;
      end
      ST_PR_JA: begin
        state_nxt = ST_PR_JB;
      end
      ST_PR_JB: begin
        rawj_nxt = raw_q;
        aisi_nxt = pj_aisi;
        sa_nxt   = '0;
        sb_nxt   = '0;
        state_nxt = ST_PR_UPD;
        if (ti_r == time_q) begin
          if (ei_r == ev_q) begin
            sa_nxt = HALF;
            sb_nxt = HALF;
          end else begin
            sa_nxt = ONE;
          end
        end else if (pj_ea) begin
          sa_nxt = ONE;
        end else if (pj_ra != '0) begin
          dvd_nxt   = DIV_W'(pj_rb) << FRAC_BITS;
          dsr_nxt   = pj_eb ? RAW_W'(pj_ra) : RAW_W'({pj_ra, 1'b0});
          rem_nxt   = '0;
          quo_nxt   = '0;
          dcnt_nxt  = DCNT_W'(DIV_W - 1);
          state_nxt = ST_PR_DIV;
        end
      end
      ST_PR_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = ST_PR_FIN;
        end
      end
      ST_PR_FIN: begin
        sb_nxt    = quo_r[SHW-1:0];
        sa_nxt    = ONE - quo_r[SHW-1:0] - SHW'(rem_r != '0);
        state_nxt = ST_PR_UPD;
      end
      ST_PR_UPD: begin
        acc_nxt = sat_add(acc_r, si);
        j_nxt   = j_r + IW'(1);
        state_nxt = j_last ? ST_PR_WI : ST_PR_JA;
      end
      ST_PR_WI: begin
        if (CW'(i_r) == cnt_r - CW'(2)) begin
          i_nxt     = '0;
          state_nxt = ST_MM_A;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = ST_PR_I;
        end
      end
      ST_MM_A: begin
        state_nxt = ST_MM_B;
      end
      ST_MM_B: begin
        if (i_r == '0) begin
          lo_nxt = raw_q;
          hi_nxt = raw_q;
        end else begin
          if (raw_q < lo_r) lo_nxt = raw_q;
          if (raw_q > hi_r) hi_nxt = raw_q;
        end
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = ST_OUT_A;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = ST_MM_A;
        end
      end
      ST_OUT_A: begin
        state_nxt = ST_OUT_B;
      end
      ST_OUT_B: begin
        state_nxt = ST_OUT_C;
      end
      ST_OUT_C: begin
        oid_nxt = id_q;
        if (flat) begin
          norm_nxt  = '0;
          state_nxt = ST_OUT_V;
        end else begin
          dvd_nxt   = {raw_q - lo_r, {NORM_FRAC{1'b0}}};
          dsr_nxt   = hi_r - lo_r;
          rem_nxt   = '0;
          quo_nxt   = '0;
          dcnt_nxt  = DCNT_W'(DIV_W - 1);
          state_nxt = ST_OUT_DIV;
        end
      end
      ST_OUT_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = ST_OUT_FIN;
        end
      end
      ST_OUT_FIN: begin
        norm_nxt  = quo_r[NORM_W-1:0];
        state_nxt = ST_OUT_V;
      end
      ST_OUT_V: begin
        if (out_res.ready) begin
          if (i_last) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = ST_OUT_A;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    evc_r  <= evc_nxt;
    idr_r  <= idr_nxt;
    ti_r   <= ti_nxt;
    ei_r   <= ei_nxt;
    idi_r  <= idi_nxt;
    ri_r   <= ri_nxt;
    acc_r  <= acc_nxt;
    rawj_r <= rawj_nxt;
    sa_r   <= sa_nxt;
    sb_r   <= sb_nxt;
    aisi_r <= aisi_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    oid_r  <= oid_nxt;
    norm_r <= norm_nxt;
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dcnt_r <= dcnt_nxt;
  end

  assign in_rec.ready       = state_r == ST_LOAD;
  assign out_res.valid      = state_r == ST_OUT_V;
  assign out_res.out_id     = oid_r;
  assign out_res.norm_score = norm_r;
  assign out_res.flat_range = flat;
  assign out_res.out_last   = i_last;

  // The store never holds more records than its depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("record count exceeds store depth");

  // A run always works on at least one record.
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> (cnt_r != '0))
    else $error("run started with an empty store");

  // Records are never taken while a result beat is offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_rec.ready && out_res.valid))
    else $error("input and output active together");

  // A pair share never exceeds one.
  a_pair_quo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PR_FIN) |-> (quo_r <= DIV_W'(ONE)))
    else $error("pair share above one");

  // A normalized score never exceeds one.
  a_norm_quo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT_FIN) |-> (quo_r <= (DIV_W'(1) << NORM_FRAC)))
    else $error("normalized score above one");

  // The last result beat returns the block to loading.
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.ready && out_res.out_last) |=> (state_r == ST_LOAD))
    else $error("block not loading after last result");

endmodule
